### rtl/rcfsk_pkg.sv
// shared types, constants and ramp table function for the raised-cosine fsk bit modulator
package rcfsk_pkg;

    localparam int RAMP_ENTRIES        = 256;
    localparam int PHASE_FRACTION_BITS = 16;
    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int MAX_SAMPLES         = 64;

    localparam int ROM_ADDR_BITS = $clog2(RAMP_ENTRIES);
    localparam int PHASE_BITS    = ROM_ADDR_BITS + PHASE_FRACTION_BITS;
    localparam int STEP_BITS     = PHASE_BITS + 1;
    localparam int AMP_BITS      = 15;
    localparam int CFG_DATA_BITS = 25;
    localparam int R_BITS        = 17;
    localparam int MAG_BITS      = 16;

    localparam logic [STEP_BITS-1:0] PHASE_WRAP = STEP_BITS'(1) << PHASE_BITS;
    localparam logic [STEP_BITS-1:0] STEP_MIN   = STEP_BITS'(PHASE_WRAP / MAX_SAMPLES);
    localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(4194304);
    localparam logic [AMP_BITS-1:0]  AMP_RESET  = AMP_BITS'(32767);

    localparam logic signed [R_BITS-1:0] LEVEL_ONE = R_BITS'(32768);

    localparam int QUARTER = RAMP_ENTRIES / 4;
    localparam int HALF    = RAMP_ENTRIES / 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef enum logic [1:0] {
        REG_PHASE_STEP = 2'd0,
        REG_AMPLITUDE  = 2'd1,
        REG_INVERT     = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [STEP_BITS-1:0] step;
        logic [AMP_BITS-1:0]  amplitude;
        logic                 invert;
    } cfg_t;

    typedef struct packed {
        logic data_bit;
        logic ramp;
    } item_t;

    typedef struct packed {
        logic [QCOUNT_BITS-1:0] count;
    } front_status_t;

    typedef struct packed {
        logic busy;
        logic adv;
    } back_status_t;

    // cos(pi*u/HALF) in q15, taylor series in q30; elaboration only
    function automatic logic [MAG_BITS-1:0] cos_q15(input logic [63:0] u);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        rnd;
        x    = (PI_Q30 * u) / HALF;
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        sum  = $signed(ONE_Q30);
        for (int k = 1; k <= 8; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 0;
        rnd = (64'(sum) + (64'd1 << 14)) >> 15;
        return rnd[MAG_BITS-1:0];
    endfunction

    // falling ramp entry in q15 with 1.0 = 32768
    function automatic logic signed [R_BITS-1:0] ramp_value(input int i);
        int t;
        t = i - QUARTER;
        if (i < QUARTER)
            return LEVEL_ONE;
        else if (i >= 3 * QUARTER)
            return -LEVEL_ONE;
        else if (2 * t > HALF)
            return -$signed({1'b0, cos_q15(64'(HALF - t))});
        else
            return $signed({1'b0, cos_q15(64'(t))});
    endfunction

endpackage

### rtl/raised_cosine_fsk_bit_modulator_core.sv
// top level of the raised-cosine fsk bit modulator: config registers, front end and back end
// path: a bit passes through the queue, the sequencer, the ramp stage, the scale stage and the output register
// throughput: one sample per cycle while out_stall is low, 1 to 64 samples per bit as set by
//   phase_step through the phase accumulator; samples of consecutive bits follow with no gap, the
//   2-entry queue takes new bits while the back end works
// reset: asynchronous active low, clears phase, line level, queue and pipeline valids;
//   registers return to phase_step 4194304, amplitude 32767, no inversion
module raised_cosine_fsk_bit_modulator_core #(
    parameter int SAMPLE_BITS = rcfsk_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input channel: one data bit per transaction
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  data_bit,
    // output channel: one sample per transaction
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [SAMPLE_BITS-1:0]         sample,
    output logic                                  last_of_bit,
    // configuration write port
    input  logic                                  cfg_we,
    input  logic [1:0]                            cfg_index,
    input  logic [rcfsk_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import rcfsk_pkg::*;

    logic [STEP_BITS-1:0] step_reg;
    logic [STEP_BITS-1:0] step_next;
    logic [AMP_BITS-1:0]  amp_reg;
    logic                 invert_reg;
    logic [STEP_BITS-1:0] step_in;
    cfg_t                 cfg;

    item_t         q_item;
    logic          q_valid;
    logic          q_pop;
    front_status_t fr_status;
    back_status_t  bk_status;

    // clamp the step at write time so a bit gives between 1 and 64 samples
    assign step_in = cfg_data[STEP_BITS-1:0];
    always_comb
    begin
        if (step_in < STEP_MIN)
            step_next = STEP_MIN;
        else if (step_in > PHASE_WRAP)
            step_next = PHASE_WRAP;
        else
            step_next = step_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= STEP_RESET;
            amp_reg    <= AMP_RESET;
            invert_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_PHASE_STEP: step_reg   <= step_next;
                REG_AMPLITUDE:  amp_reg    <= cfg_data[AMP_BITS-1:0];
                REG_INVERT:     invert_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    assign cfg.step      = step_reg;
    assign cfg.amplitude = amp_reg;
    assign cfg.invert    = invert_reg;

    // front end: takes bits, tags hold or ramp against the line level, queues them
    rcfsk_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .data_bit (data_bit),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .status   (fr_status)
    );

    // back end: steps the phase and produces scaled samples
    rcfsk_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_item      (q_item),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .status      (bk_status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample      (sample),
        .last_of_bit (last_of_bit)
    );

`ifndef SYNTHESIS
    // queue never holds more than its depth
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fr_status.count <= QCOUNT_BITS'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // back end only goes idle when nothing was waiting in the queue
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(bk_status.busy) |-> $past(fr_status.count) == '0)
        else $error("back end went idle with queued bits");

    // an idle back end picks up a waiting bit as soon as the pipeline moves
    a_pickup: assert property (@(posedge clk) disable iff (!rst_n)
        (!bk_status.busy && fr_status.count != '0 && bk_status.adv) |=> bk_status.busy)
        else $error("queued bit not picked up");
`endif

endmodule

### rtl/rcfsk_front.sv
// front end: accepts data bits, classifies hold or ramp, queues them for the back end
module rcfsk_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    data_bit,
    output rcfsk_pkg::item_t        q_item,
    output logic                    q_valid,
    input  logic                    q_pop,
    output rcfsk_pkg::front_status_t status
);
    import rcfsk_pkg::*;

    item_t                  fifo_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg;
    logic [QPTR_BITS-1:0]   rd_ptr_reg;
    logic [QCOUNT_BITS-1:0] count_reg;
    logic                   line_level_reg;
    logic                   push;
    item_t                  new_item;

    assign in_stall = (count_reg == QCOUNT_BITS'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_item   = fifo_mem[rd_ptr_reg];
    assign status.count = count_reg;

    // a bit that differs from the current line level needs the ramp
    assign new_item.data_bit = data_bit;
    assign new_item.ramp     = (data_bit != line_level_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            line_level_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg     <= QPTR_BITS'((int'(wr_ptr_reg) + 1) % QUEUE_DEPTH);
                line_level_reg <= data_bit;
            end
            if (q_pop && q_valid)
                rd_ptr_reg <= QPTR_BITS'((int'(rd_ptr_reg) + 1) % QUEUE_DEPTH);
            if (push && !(q_pop && q_valid))
                count_reg <= count_reg + 1'b1;
            else if (!push && q_pop && q_valid)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= new_item;
    end

endmodule

### rtl/rcfsk_back.sv
// back end: phase sequencer, ramp lookup, amplitude scaling and output register
module rcfsk_back #(
    parameter int SAMPLE_BITS = rcfsk_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rcfsk_pkg::cfg_t               cfg,
    input  rcfsk_pkg::item_t              q_item,
    input  logic                          q_valid,
    output logic                          q_pop,
    output rcfsk_pkg::back_status_t       status,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          last_of_bit
);
    import rcfsk_pkg::*;

    localparam logic signed [31:0] SAT_HI = 32'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [31:0] SAT_LO = -SAT_HI - 32'sd1;

    logic signed [R_BITS-1:0] ramp_tab [RAMP_ENTRIES];

    for (genvar g = 0; g < RAMP_ENTRIES; g++)
    begin : g_ramp
        assign ramp_tab[g] = ramp_value(g);
    end

    // sequencer
    logic                  busy_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    item_t                 cur_reg;
    // ramp stage
    logic                     s1_valid_reg;
    logic signed [R_BITS-1:0] s1_r_reg;
    logic                     s1_last_reg;
    // scale stage
    logic                s2_valid_reg;
    logic [MAG_BITS-1:0] s2_mag_reg;
    logic                s2_neg_reg;
    logic                s2_last_reg;
    // output stage
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          last_reg;

    logic                     adv;
    logic [STEP_BITS-1:0]     sum;
    logic                     seq_last;
    logic [ROM_ADDR_BITS-1:0] idx;
    logic signed [R_BITS-1:0] rom_d;
    logic signed [R_BITS-1:0] r_sel;
    logic [MAG_BITS-1:0]      r_mag;
    logic [31:0]              prod;
    logic signed [R_BITS-1:0] v17;
    logic signed [31:0]       v32;
    logic signed [SAMPLE_BITS-1:0] sat_next;

    assign adv      = !out_valid_reg || !out_stall;
    assign sum      = {1'b0, phase_reg} + cfg.step;
    assign seq_last = sum[PHASE_BITS];
    assign q_pop    = adv && q_valid && (!busy_reg || seq_last);
    assign idx      = phase_reg[PHASE_BITS-1 -: ROM_ADDR_BITS];
    assign rom_d    = ramp_tab[idx];

    assign status.busy = busy_reg;
    assign status.adv  = adv;

    always_comb
    begin
        if (cur_reg.ramp)
            r_sel = cur_reg.data_bit ? -rom_d : rom_d;
        else
            r_sel = cur_reg.data_bit ? LEVEL_ONE : -LEVEL_ONE;
    end

    // magnitude of q15 level times amplitude, rounded
    always_comb
    begin
        r_mag = s1_r_reg[R_BITS-1] ? MAG_BITS'(-s1_r_reg) : MAG_BITS'(s1_r_reg);
        prod  = 32'(cfg.amplitude) * 32'(r_mag) + 32'd16384;
    end

    always_comb
    begin
        v17 = s2_neg_reg ? -$signed({1'b0, s2_mag_reg}) : $signed({1'b0, s2_mag_reg});
        v32 = 32'(v17);
        if (v32 > SAT_HI)
            sat_next = SAMPLE_BITS'(SAT_HI);
        else if (v32 < SAT_LO)
            sat_next = SAMPLE_BITS'(SAT_LO);
        else
            sat_next = SAMPLE_BITS'(v32);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (busy_reg)
                phase_reg <= sum[PHASE_BITS-1:0];
            if (q_pop)
                busy_reg <= 1'b1;
            else if (busy_reg && seq_last)
                busy_reg <= 1'b0;
            s1_valid_reg  <= busy_reg;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (q_pop)
                cur_reg <= q_item;
            s1_r_reg    <= r_sel;
            s1_last_reg <= seq_last;
            s2_mag_reg  <= prod[MAG_BITS+14:15];
            s2_neg_reg  <= s1_r_reg[R_BITS-1] ^ cfg.invert;
            s2_last_reg <= s1_last_reg;
            sample_reg  <= sat_next;
            last_reg    <= s2_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign sample      = sample_reg;
    assign last_of_bit = last_reg;

endmodule
